[sv/smes_pkg.sv]
// ============================================================================
// smes_pkg: shared types and constants for the SMBus EEPROM sequencer
// Holds the opcode and status codes, bus status codes, sizes and the word
// layouts of the input and result channels.
// ============================================================================
package smes_pkg;

  // Largest data transfer and the transmit buffer geometry.
  localparam int MAX_BYTES = 32;
  localparam int BUF_DEPTH = 32;
  localparam int PTR_W     = 5;
  localparam int CNT_W     = 6;

  // Item opcodes.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_EVENT = 2'd2,
    OP_ABORT = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FAIL    = 2'd1,
    ST_REFUSED = 2'd2
  } stat_t;

  // Upper nibble of the bus status register.
  localparam logic [3:0] SC_START_SENT = 4'd14;
  localparam logic [3:0] SC_BYTE_SENT  = 4'd12;
  localparam logic [3:0] SC_BYTE_RCVD  = 4'd8;

  // Slaves that take a two-byte word offset.
  localparam logic [7:0] SLAVE_WIDE_A = 8'hA8;
  localparam logic [7:0] SLAVE_WIDE_B = 8'hB8;
  localparam logic [7:0] SLAVE_WIDE_C = 8'h24;

  // Address byte with the R/W bit cleared.
  localparam logic [7:0] ADDR_MASK = 8'hFE;

  typedef struct packed {
    op_t               opcode;
    logic [7:0]        slave_addr;
    logic [15:0]       word_offset;
    logic [CNT_W-1:0]  xfer_length;
    logic              read_req;
    logic [PTR_W-1:0]  buf_index;
    logic [7:0]        buf_byte;
    logic [3:0]        status_code;
    logic              ack_in;
    logic              arb_lost;
    logic [7:0]        rx_data;
  } item_t;

  typedef struct packed {
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              start_req;
    logic              stop_req;
    logic              ack_out;
    logic              rx_valid;
    logic [PTR_W-1:0]  rx_index;
    logic [7:0]        rx_byte;
    logic              busy_res;
    stat_t             status;
  } result_t;

  // Handshake between the input stage and the result stage.
  typedef struct packed {
    logic valid;   // input stage holds a word
    logic advance; // result stage can take a new word this cycle
  } stage_ctl_t;

endpackage

[sv/smes_ifs.sv]
// ============================================================================
// smes_ifs: valid/ready channel interfaces
// Input channel carries one sequencer item per word, the output channel one
// result per word.
// ============================================================================
interface smes_in_if;
  logic            valid;
  logic            ready;
  smes_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface smes_out_if;
  logic              valid;
  logic              ready;
  smes_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/smbus_master_eeprom_sequencer.sv]
// ============================================================================
// smbus_master_eeprom_sequencer: SMBus master sequencer for EEPROM transfers
// Flow: a word waits in the input register, its result in the result register.
// Throughput: one word per cycle while the sink is ready; the input register,
// the state update and the result register form a single-pass pipeline with
// no stall of its own.
// Reset: synchronous, active low; clears all transfer state and both stage
// valid bits. The transmit buffer holds garbage until it is loaded.
// ============================================================================
module smbus_master_eeprom_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  smes_in_if.sink    in_ch,
  smes_out_if.source out_ch
);

  // The input stage holds the next word; the core decodes it against the
  // transfer state and updates that state in the same cycle that the result
  // moves into the output register. The core only steps when the result
  // register has room, so state and results stay in lockstep.

  smes_pkg::stage_ctl_t ctl;
  smes_pkg::item_t      item;
  smes_pkg::result_t    res;
  logic                 fire;
  logic                 advance;

  smes_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .ctl     (ctl),
    .item    (item)
  );

  // Every word produces exactly one result, including buffer loads and
  // ignored events, so the result word count always matches the input.
  smes_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .item  (item),
    .fire  (fire),
    .res   (res)
  );

  // The result register frees itself whenever the sink takes its word, so
  // back-to-back words flow without bubbles.
  smes_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .res     (res),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

[sv/smes_in_reg.sv]
// ============================================================================
// smes_in_reg: input register stage
// Captures one item per cycle and holds it while the result stage stalls.
// ============================================================================
module smes_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  smes_in_if.sink             in_ch,
  input  logic                advance,
  output smes_pkg::stage_ctl_t ctl,
  output smes_pkg::item_t     item
);

  logic            valid_r;
  logic            valid_nxt;
  smes_pkg::item_t item_r;
  logic            in_fire;

  assign in_ch.ready = !valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_ch.data;
    end
  end

  assign ctl.valid   = valid_r;
  assign ctl.advance = advance;
  assign item        = item_r;

endmodule

[sv/smes_core.sv]
// ============================================================================
// smes_core: transfer state and event decode
// Holds the transfer flags, counters and transmit buffer, and turns the item
// in the input stage into one result and the next state in a single pass.
// ============================================================================
module smes_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smes_pkg::stage_ctl_t ctl,
  input  smes_pkg::item_t      item,
  output logic                 fire,
  output smes_pkg::result_t    res
);

  localparam logic [smes_pkg::CNT_W-1:0] MAX_LEN = smes_pkg::CNT_W'(smes_pkg::MAX_BYTES);

  logic busy_r, busy_nxt;
  logic dir_read_r, dir_read_nxt;
  logic send_offset_r, send_offset_nxt;
  logic random_read_r, random_read_nxt;
  logic ack_poll_r, ack_poll_nxt;
  logic pend_restart_r, pend_restart_nxt;
  logic two_byte_r, two_byte_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] target_r, target_nxt;
  logic [7:0] off_hi_r, off_hi_nxt;
  logic [7:0] off_lo_r, off_lo_nxt;
  logic [smes_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [smes_pkg::CNT_W-1:0] length_r, length_nxt;
  logic [smes_pkg::PTR_W-1:0] tx_ptr_r, tx_ptr_nxt;
  logic [smes_pkg::PTR_W-1:0] rx_ptr_r, rx_ptr_nxt;

  logic [7:0] tx_buf [smes_pkg::BUF_DEPTH];
  logic [7:0] buf_rd;
  logic [smes_pkg::CNT_W-1:0] count_inc;
  logic [1:0] phase_inc;

  assign fire      = ctl.valid && ctl.advance;
  assign buf_rd    = tx_buf[tx_ptr_r];
  assign count_inc = count_r + 1'b1;
  assign phase_inc = phase_r + 1'b1;

  always_ff @(posedge clk) begin
    if (fire && item.opcode == smes_pkg::OP_LOAD) begin
      tx_buf[item.buf_index] <= item.buf_byte;
    end
  end

  always_comb begin
    busy_nxt         = busy_r;
    dir_read_nxt     = dir_read_r;
    send_offset_nxt  = send_offset_r;
    random_read_nxt  = random_read_r;
    ack_poll_nxt     = ack_poll_r;
    pend_restart_nxt = pend_restart_r;
    two_byte_nxt     = two_byte_r;
    phase_nxt        = phase_r;
    target_nxt       = target_r;
    off_hi_nxt       = off_hi_r;
    off_lo_nxt       = off_lo_r;
    count_nxt        = count_r;
    length_nxt       = length_r;
    tx_ptr_nxt       = tx_ptr_r;
    rx_ptr_nxt       = rx_ptr_r;
    res              = '0;
    res.status       = smes_pkg::ST_OK;

    unique case (item.opcode)
      smes_pkg::OP_LOAD: begin
      end
      smes_pkg::OP_START: begin
        if (busy_r) begin
          res.status = smes_pkg::ST_REFUSED;
        end else begin
          busy_nxt         = 1'b1;
          target_nxt       = item.slave_addr;
          random_read_nxt  = item.read_req;
          ack_poll_nxt     = 1'b1;
          two_byte_nxt     = item.slave_addr == smes_pkg::SLAVE_WIDE_A ||
                             item.slave_addr == smes_pkg::SLAVE_WIDE_B ||
                             item.slave_addr == smes_pkg::SLAVE_WIDE_C;
          off_hi_nxt       = item.word_offset[15:8];
          off_lo_nxt       = item.word_offset[7:0];
          length_nxt       = (item.xfer_length > MAX_LEN) ? MAX_LEN : item.xfer_length;
          dir_read_nxt     = 1'b0;
          send_offset_nxt  = 1'b1;
          pend_restart_nxt = 1'b0;
          phase_nxt        = 2'd0;
          count_nxt        = '0;
          tx_ptr_nxt       = '0;
          rx_ptr_nxt       = '0;
          res.start_req    = 1'b1;
        end
      end
      smes_pkg::OP_ABORT: begin
        busy_nxt         = 1'b0;
        pend_restart_nxt = 1'b0;
        phase_nxt        = 2'd0;
        ack_poll_nxt     = 1'b0;
        res.status       = smes_pkg::ST_FAIL;
      end
      smes_pkg::OP_EVENT: begin
        if (busy_r) begin
          if (item.arb_lost) begin
            busy_nxt         = 1'b0;
            pend_restart_nxt = 1'b0;
            phase_nxt        = 2'd0;
            res.status       = smes_pkg::ST_FAIL;
          end else begin
            case (item.status_code)
              smes_pkg::SC_START_SENT: begin
                res.tx_valid = 1'b1;
                res.tx_byte  = (target_r & smes_pkg::ADDR_MASK) | {7'd0, dir_read_r};
                count_nxt    = '0;
              end
              smes_pkg::SC_BYTE_SENT: begin
                if (!item.ack_in) begin
                  if (ack_poll_r) begin
                    // ACK polling: the slave is still busy writing, so the
                    // whole transfer is replayed from the address byte.
                    dir_read_nxt     = 1'b0;
                    send_offset_nxt  = 1'b1;
                    pend_restart_nxt = 1'b0;
                    phase_nxt        = 2'd0;
                    count_nxt        = '0;
                    tx_ptr_nxt       = '0;
                    rx_ptr_nxt       = '0;
                    res.start_req    = 1'b1;
                  end else begin
                    busy_nxt         = 1'b0;
                    pend_restart_nxt = 1'b0;
                    phase_nxt        = 2'd0;
                    res.status       = smes_pkg::ST_FAIL;
                  end
                end else if (pend_restart_r) begin
                  pend_restart_nxt = 1'b0;
                  res.start_req    = 1'b1;
                end else if (send_offset_r) begin
                  res.tx_valid = 1'b1;
                  if (two_byte_r && phase_inc == 2'd1) begin
                    phase_nxt   = phase_inc;
                    res.tx_byte = off_hi_r;
                  end else begin
                    // Last offset byte: a random read turns around here.
                    phase_nxt       = 2'd0;
                    res.tx_byte     = off_lo_r;
                    send_offset_nxt = 1'b0;
                    if (random_read_r) begin
                      pend_restart_nxt = 1'b1;
                      dir_read_nxt     = 1'b1;
                    end
                  end
                end else if (!dir_read_r) begin
                  if (count_r < length_r) begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = buf_rd;
                    tx_ptr_nxt   = tx_ptr_r + 1'b1;
                    count_nxt    = count_inc;
                  end else begin
                    res.stop_req = 1'b1;
                    busy_nxt     = 1'b0;
                  end
                end
              end
              smes_pkg::SC_BYTE_RCVD: begin
                count_nxt    = count_inc;
                res.rx_valid = 1'b1;
                res.rx_index = rx_ptr_r;
                res.rx_byte  = item.rx_data;
                if (count_inc < length_r) begin
                  res.ack_out = 1'b1;
                  rx_ptr_nxt  = rx_ptr_r + 1'b1;
                end else begin
                  res.stop_req = 1'b1;
                  busy_nxt     = 1'b0;
                end
              end
              default: begin
                busy_nxt         = 1'b0;
                pend_restart_nxt = 1'b0;
                phase_nxt        = 2'd0;
                res.status       = smes_pkg::ST_FAIL;
              end
            endcase
          end
        end
      end
    endcase

    res.busy_res = busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b0;
      dir_read_r     <= 1'b0;
      send_offset_r  <= 1'b0;
      random_read_r  <= 1'b0;
      ack_poll_r     <= 1'b0;
      pend_restart_r <= 1'b0;
      two_byte_r     <= 1'b0;
      phase_r        <= 2'd0;
      target_r       <= '0;
      off_hi_r       <= '0;
      off_lo_r       <= '0;
      count_r        <= '0;
      length_r       <= '0;
      tx_ptr_r       <= '0;
      rx_ptr_r       <= '0;
    end else if (fire) begin
      busy_r         <= busy_nxt;
      dir_read_r     <= dir_read_nxt;
      send_offset_r  <= send_offset_nxt;
      random_read_r  <= random_read_nxt;
      ack_poll_r     <= ack_poll_nxt;
      pend_restart_r <= pend_restart_nxt;
      two_byte_r     <= two_byte_nxt;
      phase_r        <= phase_nxt;
      target_r       <= target_nxt;
      off_hi_r       <= off_hi_nxt;
      off_lo_r       <= off_lo_nxt;
      count_r        <= count_nxt;
      length_r       <= length_nxt;
      tx_ptr_r       <= tx_ptr_nxt;
      rx_ptr_r       <= rx_ptr_nxt;
    end
  end

  // A refused start must leave the transfer in progress.
  a_refuse_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.opcode == smes_pkg::OP_START && busy_r) |=> busy_r)
    else $error("refused start changed busy state");

  // A timeout abort always frees the bus and ends ACK polling.
  a_abort_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.opcode == smes_pkg::OP_ABORT) |=> (!busy_r && !ack_poll_r))
    else $error("abort left the sequencer busy");

  // A stop request always ends the transfer.
  a_stop_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.stop_req) |-> !res.busy_res)
    else $error("stop requested while staying busy");

  // A step never both transmits and receives.
  a_tx_rx_excl: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !(res.tx_valid && res.rx_valid))
    else $error("tx and rx in one step");

endmodule

[sv/smes_out_reg.sv]
// ============================================================================
// smes_out_reg: result register
// Holds one finished result until the sink takes it.
// ============================================================================
module smes_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  smes_pkg::result_t res,
  output logic              advance,
  smes_out_if.source        out_ch
);

  logic              valid_r;
  logic              valid_nxt;
  smes_pkg::result_t data_r;

  assign advance = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && advance) begin
      data_r <= res;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.data  = data_r;

endmodule
